// File: rtl/mfaf_pkg.sv
package mfaf_pkg;

   localparam int CODE_W         = 12;
   localparam int TRIG_N         = 5;
   localparam int CSR_INDEX_W    = 3;
   localparam int WINDOW_LEN_DEF = 8;
   localparam int MID_DEPTH      = 2;
   localparam int OUT_DEPTH      = 2;

   typedef logic [CODE_W-1:0] code_type;

   localparam code_type POINT_RESET = code_type'(2048);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IR_POINT    = 3'd0,
      CSR_TEMP_POINT  = 3'd1,
      CSR_CO_POINT    = 3'd2,
      CSR_CO2_POINT   = 3'd3,
      CSR_SMOKE_POINT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      LED_BLANK = 2'd0,
      LED_MARK  = 2'd1,
      LED_ALL   = 2'd2
   } led_type;

   typedef struct packed {
      code_type ir_sample;
      code_type temperature;
      code_type co_level;
      code_type co2_level;
      code_type smoke_level;
   } req_type;

   // bit order matches trigger_mask: ir is bit 4, co is bit 0
   typedef struct packed {
      logic ir;
      logic smoke;
      logic co2;
      logic temp;
      logic co;
   } trigger_type;

   typedef struct packed {
      logic                alarm_on;
      logic                warning_on;
      logic                obstructed_on;
      logic                co_cause;
      code_type            ir_average;
      led_type             led_pattern;
      logic [TRIG_N-1:0]   trigger_mask;
   } rsp_type;

   typedef struct packed {
      logic                     valid;
      logic [CSR_INDEX_W-1:0]   index;
      code_type                 data;
   } csr_write_type;

endpackage

// File: rtl/multi_sensor_fire_alarm_fusion_unit.sv
// Fire alarm sensor fusion. Each request is one evaluation tick carrying five 12-bit sensor
// codes; each produces exactly one response, in order. A request can be taken every cycle
// while the mid queue has room; with nothing backed up, a response reaches the result ports
// once its request has passed the mid queue and the response queue. The front keeps the IR
// window as a shift line with a running sum and checks every window entry against the IR set
// point in the accepting cycle; the back runs the hold-off counter and the alarm and warning
// states and divides the window sum by a reciprocal multiply, one tick per cycle while the
// response queue has room. Set points are written through the csr port, always ready, and
// should be written only with no requests in flight. No clearing pass follows reset.
module multi_sensor_fire_alarm_fusion_unit #(
   parameter int WINDOW_LEN = mfaf_pkg::WINDOW_LEN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  mfaf_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output mfaf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfaf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  mfaf_pkg::code_type                  csr_data
);

   localparam int SUM_W  = mfaf_pkg::CODE_W + $clog2(WINDOW_LEN);
   localparam int MID_W  = $bits(mfaf_pkg::trigger_type) + SUM_W;
   localparam int RSP_W  = $bits(mfaf_pkg::rsp_type);

   mfaf_pkg::csr_write_type csr;
   mfaf_pkg::trigger_type   front_trig, back_trig;
   logic [SUM_W-1:0]        front_sum, back_sum;
   logic [MID_W-1:0]        mid_rdata;
   logic [RSP_W-1:0]        out_rdata;
   mfaf_pkg::rsp_type       back_rsp;
   logic                    accept, mid_empty, out_full, fire;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid & csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign accept = req_push & ~req_full;
   assign fire   = ~mid_empty & ~out_full;

   mfaf_front #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .req      (req_data),
      .accept   (accept),
      .trig     (front_trig),
      .sum_next (front_sum)
   );

   mfaf_fifo #(
      .WIDTH (MID_W),
      .DEPTH (mfaf_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata ({front_trig, front_sum}),
      .full  (req_full),
      .pop   (fire),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign {back_trig, back_sum} = mid_rdata;

   mfaf_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .trig  (back_trig),
      .sum   (back_sum),
      .rsp   (back_rsp)
   );

   mfaf_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (mfaf_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fire),
      .wdata (back_rsp),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_data = mfaf_pkg::rsp_type'(out_rdata);

endmodule

// File: rtl/mfaf_fifo.sv
module mfaf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: rtl/mfaf_front.sv
module mfaf_front #(
   parameter int WINDOW_LEN = mfaf_pkg::WINDOW_LEN_DEF
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  mfaf_pkg::csr_write_type                            csr,
   input  mfaf_pkg::req_type                                  req,
   input  logic                                               accept,
   output mfaf_pkg::trigger_type                              trig,
   output logic [mfaf_pkg::CODE_W+$clog2(WINDOW_LEN)-1:0]     sum_next
);

   localparam int SUM_W = mfaf_pkg::CODE_W + $clog2(WINDOW_LEN);

   mfaf_pkg::code_type ir_point_ff, temp_point_ff, co_point_ff, co2_point_ff, smoke_point_ff;
   mfaf_pkg::code_type window_ff [WINDOW_LEN];
   mfaf_pkg::code_type window_in [WINDOW_LEN];
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               low_all;

   // shift line: entry 0 newest, last entry oldest
   always_comb begin
      window_in[0] = req.ir_sample;
      for (int i = 1; i < WINDOW_LEN; i++) begin
         window_in[i] = window_ff[i-1];
      end
      low_all = 1'b1;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         low_all = low_all & (window_in[i] <= ir_point_ff);
      end
      sum_in = sum_ff - SUM_W'(window_ff[WINDOW_LEN-1]) + SUM_W'(req.ir_sample);
   end

   assign sum_next   = sum_in;
   assign trig.ir    = low_all;
   assign trig.smoke = (req.smoke_level >= smoke_point_ff);
   assign trig.co2   = (req.co2_level <= co2_point_ff);
   assign trig.temp  = (req.temperature >= temp_point_ff);
   assign trig.co    = (req.co_level <= co_point_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= '0;
         end
         sum_ff <= '0;
      end else if (accept) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            window_ff[i] <= window_in[i];
         end
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ir_point_ff    <= mfaf_pkg::POINT_RESET;
         temp_point_ff  <= mfaf_pkg::POINT_RESET;
         co_point_ff    <= mfaf_pkg::POINT_RESET;
         co2_point_ff   <= mfaf_pkg::POINT_RESET;
         smoke_point_ff <= mfaf_pkg::POINT_RESET;
      end else if (csr.valid) begin
         case (mfaf_pkg::csr_index_type'(csr.index))
            mfaf_pkg::CSR_IR_POINT: begin
               ir_point_ff <= csr.data;
            end
            mfaf_pkg::CSR_TEMP_POINT: begin
               temp_point_ff <= csr.data;
            end
            mfaf_pkg::CSR_CO_POINT: begin
               co_point_ff <= csr.data;
            end
            mfaf_pkg::CSR_CO2_POINT: begin
               co2_point_ff <= csr.data;
            end
            mfaf_pkg::CSR_SMOKE_POINT: begin
               smoke_point_ff <= csr.data;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// File: rtl/mfaf_back.sv
module mfaf_back #(
   parameter int WINDOW_LEN = mfaf_pkg::WINDOW_LEN_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           fire,
   input  mfaf_pkg::trigger_type                          trig,
   input  logic [mfaf_pkg::CODE_W+$clog2(WINDOW_LEN)-1:0] sum,
   output mfaf_pkg::rsp_type                              rsp
);

   localparam int LOG_N   = $clog2(WINDOW_LEN);
   localparam int SUM_W   = mfaf_pkg::CODE_W + LOG_N;
   localparam int SHIFT   = SUM_W + LOG_N;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
   localparam int HOLD_W  = $clog2(WINDOW_LEN + 4);

   logic [HOLD_W-1:0] hold_ff, hold_in, hold_dec;
   logic              alarm_ff, alarm_in, warning_ff, warning_in;
   logic              held, alarm_keep, warning_keep, alarm_hit, obstructed;
   logic [PROD_W-1:0] product;
   mfaf_pkg::led_type led;

   always_comb begin
      held = alarm_ff | warning_ff;
      if (!held) begin
         hold_dec = '0;
      end else if (hold_ff >= HOLD_W'(WINDOW_LEN)) begin
         hold_dec = HOLD_W'(WINDOW_LEN - 1);
      end else if (hold_ff != '0) begin
         hold_dec = hold_ff - HOLD_W'(1);
      end else begin
         hold_dec = '0;
      end
      alarm_keep   = alarm_ff & (hold_dec != '0);
      warning_keep = warning_ff & (hold_dec != '0);

      hold_in = hold_dec + HOLD_W'(trig.co) + HOLD_W'(trig.temp) + HOLD_W'(trig.co2)
              + HOLD_W'(trig.smoke);
      alarm_hit  = alarm_keep | trig.co;
      obstructed = (hold_in < HOLD_W'(2)) & trig.ir & ~alarm_hit;

      if (hold_in >= HOLD_W'(2)) begin
         alarm_in   = 1'b1;
         warning_in = warning_keep;
      end else if ((hold_in == HOLD_W'(1)) && !alarm_hit) begin
         alarm_in   = alarm_hit;
         warning_in = 1'b1;
      end else begin
         alarm_in   = alarm_hit;
         warning_in = 1'b0;
      end

      if (alarm_in) begin
         led = mfaf_pkg::LED_ALL;
      end else if (warning_in || obstructed) begin
         led = mfaf_pkg::LED_MARK;
      end else begin
         led = mfaf_pkg::LED_BLANK;
      end
   end

   // exact floor division by the window length via reciprocal
   assign product = PROD_W'(sum) * PROD_W'(RECIP_W'(RECIP));

   assign rsp.alarm_on      = alarm_in;
   assign rsp.warning_on    = warning_in;
   assign rsp.obstructed_on = obstructed;
   assign rsp.co_cause      = trig.co;
   assign rsp.ir_average    = product[SHIFT +: mfaf_pkg::CODE_W];
   assign rsp.led_pattern   = led;
   assign rsp.trigger_mask  = trig;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff    <= '0;
         alarm_ff   <= 1'b0;
         warning_ff <= 1'b0;
      end else if (fire) begin
         hold_ff    <= hold_in;
         alarm_ff   <= alarm_in;
         warning_ff <= warning_in;
      end
   end

endmodule

// File: rtl/mfaf_checker.sv
module mfaf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input mfaf_pkg::rsp_type                   rsp_data
);

   // nothing survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   // an accepted request leaves the response queue non-empty
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> ##1 !rsp_empty)
      else $error("accepted request produced no response in time");

   // a waiting response holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting response changed or vanished");

   // led, alarm, co cause and obstruction agree
   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_data.alarm_on == (rsp_data.led_pattern == mfaf_pkg::LED_ALL))
         && (rsp_data.co_cause == rsp_data.trigger_mask[0])
         && (!rsp_data.co_cause || rsp_data.alarm_on)
         && (!rsp_data.obstructed_on || (!rsp_data.alarm_on && rsp_data.trigger_mask[4]))))
      else $error("response fields inconsistent");

endmodule

bind multi_sensor_fire_alarm_fusion_unit mfaf_checker u_mfaf_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WIN = mfaf_pkg::WINDOW_LEN_DEF;
   localparam int STALL_LIMIT = 1000;
   localparam mfaf_pkg::code_type CODE_MAX = mfaf_pkg::code_type'(4095);
   localparam logic [mfaf_pkg::CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [mfaf_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LAST = 3'd7;

   class alarm_scoreboard;
      mfaf_pkg::code_type ir_point, temp_point, co_point, co2_point, smoke_point;
      mfaf_pkg::code_type ir_line[WIN];
      int unsigned line_head, line_sum, hold_count;
      bit alarm_held, warning_held;
      mfaf_pkg::rsp_type outcome_q[$];
      int unsigned error_count, tick_count, checked_count;
      int unsigned alarm_ticks, warning_count, obstructed_count, overlap_count;

      function new();
         ir_point = mfaf_pkg::POINT_RESET;
         temp_point = mfaf_pkg::POINT_RESET;
         co_point = mfaf_pkg::POINT_RESET;
         co2_point = mfaf_pkg::POINT_RESET;
         smoke_point = mfaf_pkg::POINT_RESET;
         foreach (ir_line[i]) ir_line[i] = '0;
         line_head = 0;
         line_sum = 0;
         hold_count = 0;
         alarm_held = 0;
         warning_held = 0;
      endfunction

      function void write_point(logic [mfaf_pkg::CSR_INDEX_W-1:0] index,
                                mfaf_pkg::code_type value);
         case (mfaf_pkg::csr_index_type'(index))
            mfaf_pkg::CSR_IR_POINT: ir_point = value;
            mfaf_pkg::CSR_TEMP_POINT: temp_point = value;
            mfaf_pkg::CSR_CO_POINT: co_point = value;
            mfaf_pkg::CSR_CO2_POINT: co2_point = value;
            mfaf_pkg::CSR_SMOKE_POINT: smoke_point = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return outcome_q.size();
      endfunction

      function void note_request(mfaf_pkg::req_type r);
         mfaf_pkg::trigger_type trig;
         int unsigned low_count;
         bit blocked;
         mfaf_pkg::rsp_type want;
         line_sum = line_sum - ir_line[line_head] + r.ir_sample;
         ir_line[line_head] = r.ir_sample;
         line_head = (line_head + 1) % WIN;
         low_count = 0;
         foreach (ir_line[i]) if (ir_line[i] <= ir_point) low_count++;
         trig.ir = (low_count == WIN);
         trig.temp = (r.temperature >= temp_point);
         trig.co = (r.co_level <= co_point);
         trig.co2 = (r.co2_level <= co2_point);
         trig.smoke = (r.smoke_level >= smoke_point);
         // hold-off decay
         if (alarm_held || warning_held) begin
            if (hold_count >= WIN) hold_count = WIN - 1;
            else if (hold_count > 0) hold_count--;
            if (hold_count == 0) begin
               alarm_held = 0;
               warning_held = 0;
            end
         end else begin
            hold_count = 0;
         end
         if (trig.co) begin
            hold_count++;
            alarm_held = 1;
         end
         hold_count += int'(trig.temp) + int'(trig.co2) + int'(trig.smoke);
         blocked = (hold_count < 2) && trig.ir && !alarm_held;
         if (hold_count >= 2 && !blocked) alarm_held = 1;
         else if (hold_count == 1 && !alarm_held) warning_held = 1;
         else warning_held = 0;
         want.alarm_on = alarm_held;
         want.warning_on = warning_held;
         want.obstructed_on = blocked;
         want.co_cause = trig.co;
         want.ir_average = mfaf_pkg::code_type'(line_sum / WIN);
         if (alarm_held) want.led_pattern = mfaf_pkg::LED_ALL;
         else if (warning_held || blocked) want.led_pattern = mfaf_pkg::LED_MARK;
         else want.led_pattern = mfaf_pkg::LED_BLANK;
         want.trigger_mask = trig;
         outcome_q.push_back(want);
         tick_count++;
         alarm_ticks += alarm_held;
         warning_count += warning_held;
         obstructed_count += blocked;
         overlap_count += alarm_held && warning_held;
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
         end
      endfunction

      function void check_response(mfaf_pkg::rsp_type got);
         mfaf_pkg::rsp_type want;
         if (outcome_q.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
            return;
         end
         want = outcome_q.pop_front();
         checked_count++;
         compare_field("alarm_on", want.alarm_on, got.alarm_on);
         compare_field("warning_on", want.warning_on, got.warning_on);
         compare_field("obstructed_on", want.obstructed_on, got.obstructed_on);
         compare_field("co_cause", want.co_cause, got.co_cause);
         compare_field("ir_average", want.ir_average, got.ir_average);
         compare_field("led_pattern", want.led_pattern, got.led_pattern);
         compare_field("trigger_mask", want.trigger_mask, got.trigger_mask);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   mfaf_pkg::req_type req_data;
   logic rsp_empty;
   logic rsp_pop;
   mfaf_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [mfaf_pkg::CSR_INDEX_W-1:0] csr_index;
   mfaf_pkg::code_type csr_data;

   alarm_scoreboard board;
   bit req_quiet, rsp_quiet, ir_run_low;
   int unsigned stalled_cycles = 0;
   int unsigned setting_count = 1;

   multi_sensor_fire_alarm_fusion_unit i_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $error("no handshake for %0d cycles", STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // triggers when value >= p
   function automatic mfaf_pkg::code_type draw_high(int p, bit trig);
      if (trig || p == 0)
         return mfaf_pkg::code_type'(($urandom_range(3, 0) == 0) ? p
                                     : $urandom_range(4095, p));
      return mfaf_pkg::code_type'(($urandom_range(3, 0) == 0) ? p - 1
                                  : $urandom_range(p - 1, 0));
   endfunction

   // triggers when value <= p
   function automatic mfaf_pkg::code_type draw_low(int p, bit trig);
      if (trig || p == 4095)
         return mfaf_pkg::code_type'(($urandom_range(3, 0) == 0) ? p
                                     : $urandom_range(p, 0));
      return mfaf_pkg::code_type'(($urandom_range(3, 0) == 0) ? p + 1
                                  : $urandom_range(4095, p + 1));
   endfunction

   function automatic mfaf_pkg::req_type make_tick(int ir, int temp, int co, int co2,
                                                   int smoke);
      mfaf_pkg::req_type t;
      t.ir_sample = mfaf_pkg::code_type'(ir);
      t.temperature = mfaf_pkg::code_type'(temp);
      t.co_level = mfaf_pkg::code_type'(co);
      t.co2_level = mfaf_pkg::code_type'(co2);
      t.smoke_level = mfaf_pkg::code_type'(smoke);
      return t;
   endfunction

   function automatic mfaf_pkg::req_type random_tick();
      mfaf_pkg::req_type t;
      logic [3:0] wanted;
      int r;
      r = $urandom_range(99, 0);
      if (r < 35) begin
         wanted = '0;
      end else if (r < 60) begin
         wanted = 4'b0001 << $urandom_range(3, 0);
      end else if (r < 80) begin
         wanted = 4'($urandom);
         while ($countones(wanted) < 2) wanted = 4'($urandom);
      end else begin
         wanted = 4'($urandom);
      end
      if ($urandom_range(14, 0) == 0) ir_run_low = !ir_run_low;
      t.ir_sample = draw_low(int'(board.ir_point),
         ir_run_low ? ($urandom_range(9, 0) != 0) : ($urandom_range(3, 0) == 0));
      t.co_level = draw_low(int'(board.co_point), wanted[0]);
      t.temperature = draw_high(int'(board.temp_point), wanted[1]);
      t.co2_level = draw_low(int'(board.co2_point), wanted[2]);
      t.smoke_level = draw_high(int'(board.smoke_point), wanted[3]);
      return t;
   endfunction

   task automatic send_tick(mfaf_pkg::req_type t);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_request(t);
      if ($urandom_range(39, 0) == 0) req_quiet = !req_quiet;
   endtask

   task automatic drain_responses();
      int gap;
      forever begin
         gap = pick_gap(rsp_quiet);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         board.check_response(rsp_data);
         if ($urandom_range(39, 0) == 0) rsp_quiet = !rsp_quiet;
      end
   endtask

   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [mfaf_pkg::CSR_INDEX_W-1:0] index,
                            mfaf_pkg::code_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_point(index, value);
   endtask

   task automatic program_points(int ir, int temp, int co, int co2, int smoke);
      write_csr(mfaf_pkg::CSR_IR_POINT, mfaf_pkg::code_type'(ir));
      write_csr(mfaf_pkg::CSR_TEMP_POINT, mfaf_pkg::code_type'(temp));
      write_csr(mfaf_pkg::CSR_CO_POINT, mfaf_pkg::code_type'(co));
      write_csr(mfaf_pkg::CSR_CO2_POINT, mfaf_pkg::code_type'(co2));
      write_csr(mfaf_pkg::CSR_SMOKE_POINT, mfaf_pkg::code_type'(smoke));
      // unmapped index must leave every point alone
      write_csr(mfaf_pkg::CSR_INDEX_W'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)),
                mfaf_pkg::code_type'($urandom));
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   task automatic run_directed();
      // quiet sensors at the reset points: temp 0, co 4095, co2 4095, smoke 0
      send_tick(make_tick(0, 0, 4095, 4095, 0));          // zero window, obstructed
      send_tick(make_tick(4095, 0, 4095, 4095, 0));
      send_tick(make_tick(4095, 4095, 4095, 4095, 0));    // single sensor warning
      send_tick(make_tick(4095, 0, 4095, 4095, 0));
      send_tick(make_tick(4095, 0, 0, 4095, 0));          // co alone raises alarm
      repeat (2) send_tick(make_tick(4095, 0, 4095, 4095, 0));
      repeat (3) send_tick(make_tick(4095, 4095, 0, 0, 4095));  // hold count clipping
      repeat (4) send_tick(make_tick(4095, 0, 4095, 4095, 0));
      send_tick(make_tick(2048, 2048, 2048, 2048, 2048)); // exactly at the points
      send_tick(make_tick(2049, 2047, 2049, 2049, 2047)); // one code off the points
      send_tick(make_tick(0, 0, 0, 0, 0));
      send_tick(make_tick(4095, 4095, 4095, 4095, 4095));
      send_tick(make_tick(4095, 0, 4095, 4095, 4095));
      send_tick(make_tick(4095, 0, 4095, 0, 0));
      send_tick(make_tick(4095, 4095, 4095, 4095, 4095)); // two sensors, fire
      repeat (5) send_tick(make_tick(0, 0, 4095, 4095, 0));
      send_tick(make_tick(0, 4095, 4095, 4095, 0));       // low ir sample with one other
   endtask

   task automatic run_random(int count);
      repeat (count) send_tick(random_tick());
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      ir_run_low = 1'b0;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      fork
         drain_responses();
      join_none
      run_directed();
      run_random(90);
      settle();
      program_points(0, 0, 0, 0, 0);
      run_random(70);
      settle();
      program_points(4095, 4095, 4095, 4095, 4095);
      run_random(70);
      repeat (3) begin
         settle();
         program_points($urandom_range(4095, 0), $urandom_range(3500, 500),
            $urandom_range(3500, 500), $urandom_range(3500, 500), $urandom_range(3500, 500));
         run_random(70);
      end
      settle();
      repeat (6) @(posedge clock);
      $display("run: %0d ticks checked over %0d set-point settings", board.checked_count,
         setting_count);
      $display("seen: %0d alarm, %0d warning, %0d obstructed, %0d alarm with warning",
         board.alarm_ticks, board.warning_count, board.obstructed_count, board.overlap_count);
      if (board.error_count == 0 && board.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/mfaf_pkg.sv
rtl/mfaf_fifo.sv
rtl/mfaf_front.sv
rtl/mfaf_back.sv
rtl/multi_sensor_fire_alarm_fusion_unit.sv
rtl/mfaf_checker.sv
verif/tb.sv
